@@ src/bbvq_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and control structs for the bounding box vertex quantizer
// no dependencies; imported by every module of the block

package bbvq_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int OUT_W          = 32;
    localparam int QP_W           = 5;
    localparam int QW             = 24;
    localparam int MARGIN_W       = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [QP_W-1:0]     QP_MIN       = 5'd1;
    localparam logic [QP_W-1:0]     QP_MAX       = 5'd24;
    localparam logic [QP_W-1:0]     QP_RESET     = 5'd20;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1311;

    // item operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_QUANT   = 2'd1;
    localparam logic [1:0] OP_DEQUANT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MARGIN = 1'b1;

    // box update request from the sequencer
    typedef struct packed {
        logic add;
        logic restart;
    } box_upd_t;

    // per-axis lane command
    typedef struct packed {
        logic start;
        logic deq;
    } lane_ctrl_t;

endpackage

@@ src/bbvq_box.sv @@
`timescale 1ns / 1ps
// bounding box store plus registered extent / range pipeline
// depends on bbvq_pkg

module bbvq_box #(
    parameter int COORD_BITS = bbvq_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbvq_pkg::box_upd_t                upd,
    input  logic signed [COORD_BITS-1:0]      pt_x,
    input  logic signed [COORD_BITS-1:0]      pt_y,
    input  logic signed [COORD_BITS-1:0]      pt_z,
    input  logic [bbvq_pkg::MARGIN_W-1:0]     margin,
    output logic                              box_valid,
    output logic signed [COORD_BITS-1:0]      box_min_x,
    output logic signed [COORD_BITS-1:0]      box_min_y,
    output logic signed [COORD_BITS-1:0]      box_min_z,
    output logic [COORD_BITS+1:0]             range
);
    import bbvq_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = W + 1;
    localparam int RW = W + 2;

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [W-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [W-1:0] min_x_next, min_y_next, min_z_next;
    logic signed [W-1:0] max_x_next, max_y_next, max_z_next;
    logic                valid_reg, valid_next;

    logic [EW-1:0] ext_x_reg, ext_y_reg, ext_z_reg;
    logic [EW-1:0] emax_reg, emax_next, exy;
    logic [RW-1:0] range_reg;

    always_comb
    begin
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        min_z_next = min_z_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        max_z_next = max_z_reg;
        valid_next = valid_reg;
        if (upd.add)
        begin
            valid_next = 1'b1;
            if (upd.restart || !valid_reg)
            begin
                min_x_next = pt_x;
                min_y_next = pt_y;
                min_z_next = pt_z;
                max_x_next = pt_x;
                max_y_next = pt_y;
                max_z_next = pt_z;
            end
            else
            begin
                if (pt_x < min_x_reg) min_x_next = pt_x;
                if (pt_x > max_x_reg) max_x_next = pt_x;
                if (pt_y < min_y_reg) min_y_next = pt_y;
                if (pt_y > max_y_reg) max_y_next = pt_y;
                if (pt_z < min_z_reg) min_z_next = pt_z;
                if (pt_z > max_z_reg) max_z_next = pt_z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= CMAX;
            min_y_reg <= CMAX;
            min_z_reg <= CMAX;
            max_x_reg <= CMIN;
            max_y_reg <= CMIN;
            max_z_reg <= CMIN;
            valid_reg <= 1'b0;
        end
        else
        begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            min_z_reg <= min_z_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
            max_z_reg <= max_z_next;
            valid_reg <= valid_next;
        end
    end

    // largest extent, two compares
    assign exy       = (ext_x_reg >= ext_y_reg) ? ext_x_reg : ext_y_reg;
    assign emax_next = (exy >= ext_z_reg) ? exy : ext_z_reg;

    // extents, largest extent, padded range: one stage each
    always_ff @(posedge clk)
    begin
        ext_x_reg <= EW'(max_x_reg) - EW'(min_x_reg);
        ext_y_reg <= EW'(max_y_reg) - EW'(min_y_reg);
        ext_z_reg <= EW'(max_z_reg) - EW'(min_z_reg);
        emax_reg  <= emax_next;
        range_reg <= RW'(emax_reg) + RW'({margin, 1'b0});
    end

    assign box_valid = valid_reg;
    assign box_min_x = min_x_reg;
    assign box_min_y = min_y_reg;
    assign box_min_z = min_z_reg;
    assign range     = range_reg;

endmodule

@@ src/bbvq_lane.sv @@
`timescale 1ns / 1ps
// one axis: bit-serial restoring divider for quantize,
// shift-add multiplier and rounding shift for dequantize; depends on bbvq_pkg

module bbvq_lane #(
    parameter int COORD_BITS = bbvq_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbvq_pkg::lane_ctrl_t              ctrl,
    input  logic signed [COORD_BITS-1:0]      coord,
    input  logic signed [COORD_BITS-1:0]      box_min,
    input  logic [bbvq_pkg::MARGIN_W-1:0]     margin,
    input  logic [COORD_BITS+1:0]             range,
    input  logic [bbvq_pkg::QP_W-1:0]         qp,
    output logic                              done,
    output logic [bbvq_pkg::OUT_W-1:0]        res
);
    import bbvq_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = W + 2;
    localparam int RW = W + 2;
    localparam int PW = W + RW;
    localparam int SW = W + 3;
    localparam int XW = (W > OUT_W) ? W : OUT_W;
    localparam int CW = $clog2(((W > QW) ? W : QW) + 1);

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [11:0] {
        L_IDLE  = 12'b000000000001,
        L_QSUB  = 12'b000000000010,
        L_QADD  = 12'b000000000100,
        L_QCMP  = 12'b000000001000,
        L_DIV   = 12'b000000010000,
        L_DABS  = 12'b000000100000,
        L_MUL   = 12'b000001000000,
        L_SHIFT = 12'b000010000000,
        L_FIX   = 12'b000100000000,
        L_DADD  = 12'b001000000000,
        L_SAT   = 12'b010000000000,
        L_DONE  = 12'b100000000000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic signed [DW-1:0] d_reg, d_next;
    logic signed [DW-1:0] lo_reg, lo_next;
    logic [RW-1:0]        r_reg, r_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [W-1:0]         a_reg, a_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [RW-1:0]        t_reg, t_next;
    logic signed [SW-1:0] s_reg, s_next;
    logic                 neg_reg, neg_next;
    logic                 sticky_reg, sticky_next;
    logic                 big_reg, big_next;
    logic [OUT_W-1:0]     res_reg, res_next;

    logic signed [DW-1:0] marg_ext;
    logic [RW:0]          r2, r2_sub, range_ext;
    logic                 div_ge;
    logic [RW:0]          mul_sum;
    logic [QW:0]          one_sh;
    logic [QW-1:0]        top_q;
    logic signed [SW-1:0] lo_ext, t_ext;
    logic                 s_ovf;
    logic signed [W-1:0]  sat_val;
    logic signed [XW-1:0] sat_wide;
    logic                 cnt_last;

    assign marg_ext  = signed'(DW'(margin));
    assign range_ext = {1'b0, range};
    assign r2        = {r_reg, 1'b0};
    assign r2_sub    = r2 - range_ext;
    assign div_ge    = (r2 >= range_ext);
    assign mul_sum   = {1'b0, p_reg[PW-1:W]} + (a_reg[0] ? range_ext : '0);
    assign one_sh    = (QW+1)'(1) << qp;
    assign top_q     = one_sh[QW-1:0] - QW'(1);
    assign lo_ext    = SW'(lo_reg);
    assign t_ext     = signed'({1'b0, t_reg});
    assign cnt_last  = (cnt_reg == CW'(1));

    // sum out of coordinate range when the guard bits disagree
    assign s_ovf = (s_reg[SW-1:W-1] != '0) && (s_reg[SW-1:W-1] != '1);

    always_comb
    begin
        if (big_reg)
            sat_val = neg_reg ? CMIN : CMAX;
        else if (s_ovf)
            sat_val = s_reg[SW-1] ? CMIN : CMAX;
        else
            sat_val = s_reg[W-1:0];
    end

    assign sat_wide = XW'(sat_val);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        d_next      = d_reg;
        lo_next     = lo_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        a_next      = a_reg;
        p_next      = p_reg;
        t_next      = t_reg;
        s_next      = s_reg;
        neg_next    = neg_reg;
        sticky_next = sticky_reg;
        big_next    = big_reg;
        res_next    = res_reg;
        unique case (state_reg) inside
            L_IDLE, L_DONE:
            begin
                if (ctrl.start)
                    state_next = ctrl.deq ? L_DABS : L_QSUB;
            end
            L_QSUB:
            begin
                d_next     = DW'(coord) - DW'(box_min);
                state_next = L_QADD;
            end
            L_QADD:
            begin
                // distance from the padded minimum
                d_next     = d_reg + marg_ext;
                state_next = L_QCMP;
            end
            L_QCMP:
            begin
                if (d_reg[DW-1] || (d_reg == '0))
                begin
                    res_next   = '0;
                    state_next = L_DONE;
                end
                else if (d_reg[RW-1:0] >= range)
                begin
                    res_next   = OUT_W'(top_q);
                    state_next = L_DONE;
                end
                else
                begin
                    r_next     = d_reg[RW-1:0];
                    q_next     = '0;
                    cnt_next   = CW'(qp);
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                // one quotient bit per cycle
                r_next   = div_ge ? r2_sub[RW-1:0] : r2[RW-1:0];
                q_next   = {q_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_last)
                begin
                    res_next   = OUT_W'(q_next);
                    state_next = L_DONE;
                end
            end
            L_DABS:
            begin
                neg_next    = coord[W-1];
                a_next      = coord[W-1] ? (~coord + 1'b1) : coord;
                lo_next     = DW'(box_min) - marg_ext;
                p_next      = '0;
                sticky_next = 1'b0;
                cnt_next    = CW'(W);
                state_next  = L_MUL;
            end
            L_MUL:
            begin
                // multiplier bits lsb first, partial product shifts right
                p_next   = {mul_sum, p_reg[W-1:1]};
                a_next   = a_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_last)
                begin
                    cnt_next   = CW'(qp);
                    state_next = L_SHIFT;
                end
            end
            L_SHIFT:
            begin
                // divide by 2^qp, remember any bit dropped
                sticky_next = sticky_reg | p_reg[0];
                p_next      = p_reg >> 1;
                cnt_next    = cnt_reg - CW'(1);
                if (cnt_last)
                    state_next = L_FIX;
            end
            L_FIX:
            begin
                // negative values round toward minus infinity
                t_next     = {1'b0, p_reg[W:0]} + RW'(neg_reg & sticky_reg);
                big_next   = |p_reg[PW-1:W+1];
                state_next = L_DADD;
            end
            L_DADD:
            begin
                s_next     = neg_reg ? (lo_ext - t_ext) : (lo_ext + t_ext);
                state_next = L_SAT;
            end
            L_SAT:
            begin
                res_next   = sat_wide[OUT_W-1:0];
                state_next = L_DONE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        lo_reg     <= lo_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        a_reg      <= a_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        s_reg      <= s_next;
        neg_reg    <= neg_next;
        sticky_reg <= sticky_next;
        big_reg    <= big_next;
        res_reg    <= res_next;
    end

    assign done = (state_reg == L_DONE);
    assign res  = res_reg;

endmodule

@@ src/bounding_box_vertex_quantizer_core.sv @@
`timescale 1ns / 1ps
// top level of the bounding box vertex quantizer: sequencer, config registers,
// output register; depends on bbvq_pkg, bbvq_box and bbvq_lane

// The block keeps an axis-aligned bounding box of Q16.16 points and maps
// points to and from a 2^qp integer grid spanning that box, padded by the
// margin on each side. An add item (op 0) updates the box at acceptance and
// gives no result; the next item can follow in the very next cycle. A
// quantize item runs through the bit-serial restoring divider, which produces
// one quantized bit per cycle in each axis lane; a point outside the padded
// box skips the divider. A dequantize item runs through the shift-add
// multiplier (one bit of the grid value per cycle) followed by the
// one-bit-per-cycle shift by qp. Before either, the sequencer passes through
// S_PRE1, S_PRE2 and S_START while the registered extent / range pipeline
// settles. Quantize or dequantize before any box is built returns a zero
// item with no_box set through the S_EMPTY state, once the output register
// is free. One item is in flight at a time;
// a finished result sits in the output register so the next item can be
// accepted while it waits to be taken.

module bounding_box_vertex_quantizer_core #(
    parameter int COORD_BITS = bbvq_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [bbvq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bbvq_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input item channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            op,
    input  logic                                  first,
    input  logic signed [COORD_BITS-1:0]          coord_x,
    input  logic signed [COORD_BITS-1:0]          coord_y,
    input  logic signed [COORD_BITS-1:0]          coord_z,
    // result item channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bbvq_pkg::OUT_W-1:0]     out_x,
    output logic signed [bbvq_pkg::OUT_W-1:0]     out_y,
    output logic signed [bbvq_pkg::OUT_W-1:0]     out_z,
    output logic                                  no_box
);
    import bbvq_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int RW = W + 2;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRE1  = 6'b000010,
        S_PRE2  = 6'b000100,
        S_START = 6'b001000,
        S_RUN   = 6'b010000,
        S_EMPTY = 6'b100000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // configuration
    logic [QP_W-1:0]     quant_bits_reg;
    logic [MARGIN_W-1:0] box_margin_reg;
    logic [QP_W-1:0]     qp_eff;

    // held item
    logic                deq_reg, deq_next;
    logic signed [W-1:0] x_reg, y_reg, z_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [OUT_W-1:0]    out_x_next, out_y_next, out_z_next;
    logic                no_box_reg, no_box_next;
    logic                out_free, load;

    logic                accept;
    box_upd_t            box_upd;
    lane_ctrl_t          lane_ctrl;
    logic                box_valid;
    logic signed [W-1:0] box_min_x, box_min_y, box_min_z;
    logic [RW-1:0]       range;
    logic                done_x, done_y, done_z, all_done;
    logic [OUT_W-1:0]    res_x, res_y, res_z;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // out-of-range qp clamps to 1..24
    always_comb
    begin
        if (quant_bits_reg < QP_MIN)
            qp_eff = QP_MIN;
        else if (quant_bits_reg > QP_MAX)
            qp_eff = QP_MAX;
        else
            qp_eff = quant_bits_reg;
    end

    // config writes land at the edge they are offered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_bits_reg <= QP_RESET;
            box_margin_reg <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANT_BITS: quant_bits_reg <= cfg_data[QP_W-1:0];
                CFG_BOX_MARGIN: box_margin_reg <= cfg_data[MARGIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // an add item updates the box directly at acceptance
    assign box_upd.add     = accept && (op == OP_ADD);
    assign box_upd.restart = first;

    assign lane_ctrl.start = (state_reg == S_START);
    assign lane_ctrl.deq   = deq_reg;

    assign all_done = done_x && done_y && done_z;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        deq_next    = deq_reg;
        load        = 1'b0;
        out_x_next  = out_x_reg;
        out_y_next  = out_y_reg;
        out_z_next  = out_z_reg;
        no_box_next = no_box_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op) inside
                        OP_QUANT, OP_DEQUANT:
                        begin
                            deq_next   = (op == OP_DEQUANT);
                            state_next = box_valid ? S_PRE1 : S_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            // range pipeline settles over these cycles
            S_PRE1:  state_next = S_PRE2;
            S_PRE2:  state_next = S_START;
            S_START: state_next = S_RUN;
            S_RUN:
            begin
                if (all_done && out_free)
                begin
                    load        = 1'b1;
                    out_x_next  = res_x;
                    out_y_next  = res_y;
                    out_z_next  = res_z;
                    no_box_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    out_x_next  = '0;
                    out_y_next  = '0;
                    out_z_next  = '0;
                    no_box_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            deq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deq_reg       <= deq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= coord_x;
            y_reg <= coord_y;
            z_reg <= coord_z;
        end
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_z_reg  <= out_z_next;
        no_box_reg <= no_box_next;
    end

    bbvq_box #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (box_upd),
        .pt_x      (coord_x),
        .pt_y      (coord_y),
        .pt_z      (coord_z),
        .margin    (box_margin_reg),
        .box_valid (box_valid),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .range     (range)
    );

    // one serial lane per axis, all sharing the same range and qp
    bbvq_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .coord   (x_reg),
        .box_min (box_min_x),
        .margin  (box_margin_reg),
        .range   (range),
        .qp      (qp_eff),
        .done    (done_x),
        .res     (res_x)
    );

    bbvq_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .coord   (y_reg),
        .box_min (box_min_y),
        .margin  (box_margin_reg),
        .range   (range),
        .qp      (qp_eff),
        .done    (done_y),
        .res     (res_y)
    );

    bbvq_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .coord   (z_reg),
        .box_min (box_min_z),
        .margin  (box_margin_reg),
        .range   (range),
        .qp      (qp_eff),
        .done    (done_z),
        .res     (res_z)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = signed'(out_x_reg);
    assign out_y     = signed'(out_y_reg);
    assign out_z     = signed'(out_z_reg);
    assign no_box    = no_box_reg;

endmodule

@@ src/bbvq_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the bounding box vertex quantizer, bound to the top level
// depends on bbvq_pkg and bounding_box_vertex_quantizer_core

module bbvq_checker #(
    parameter int COORD_BITS = bbvq_pkg::COORD_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [1:0]                        op,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [bbvq_pkg::OUT_W-1:0] out_x,
    input logic signed [bbvq_pkg::OUT_W-1:0] out_y,
    input logic signed [bbvq_pkg::OUT_W-1:0] out_z,
    input logic                              no_box
);
    import bbvq_pkg::*;

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y)
                                   && $stable(out_z) && $stable(no_box))
        else $error("result payload changed while stalled");

    // an item without a box carries zero coordinates
    a_nobox_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_box |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
        else $error("no_box result with nonzero coordinates");

    // a quantize or dequantize item keeps the block busy in the next cycle
    a_busy_after_map: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((op == OP_QUANT) || (op == OP_DEQUANT)) |=> in_stall)
        else $error("block took a new item while mapping");

endmodule

bind bounding_box_vertex_quantizer_core bbvq_checker #(
    .COORD_BITS (COORD_BITS)
) u_bbvq_checker (.*);
